// ----- design/bsc_pkg.sv -----
package bsc_pkg;

    localparam int unsigned DIV_STEPS = 64;

    localparam logic [2:0] CFG_TEMP_COEFFS  = 3'd0;
    localparam logic [2:0] CFG_PRESS_A      = 3'd1;
    localparam logic [2:0] CFG_PRESS_B      = 3'd2;
    localparam logic [2:0] CFG_PRESS_NINE   = 3'd3;
    localparam logic [2:0] CFG_SEA_LEVEL    = 3'd4;

    localparam logic [16:0] DEFAULT_SEA_PA  = 17'd101325;
    localparam logic [20:0] RAW_FULL_SCALE  = 21'd1048576;
    localparam logic [26:0] T_FINE_OFFSET   = 27'd128000;
    localparam logic [11:0] PRESS_SCALE     = 12'd3125;
    localparam logic [63:0] X1_OFFSET       = 64'h0000_8000_0000_0000;
    localparam logic [20:0] ALT_SCALE_CM    = 21'd843400;

    typedef struct packed {
        logic [23:0] temp;
        logic [31:0] q8;
        logic        dz;
    } t_tag;

endpackage

// ----- design/baro_sensor_compensation.sv -----
// Barometric compensation pipeline: one raw temperature/pressure request is accepted every
// clock unless a result waits at the output for i_ready; each request flows through the front
// stages, the two 64-stage restoring dividers (pressure quotient, then altitude quotient) and
// the stages between them. Calibration registers are written through the config channel, which
// is always ready; write them only while no request is in flight.
module baro_sensor_compensation (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [19:0]        i_raw_temp,
    input  logic [19:0]        i_raw_press,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [23:0] o_temp_centi,
    output logic [31:0]        o_press_q8,
    output logic signed [23:0] o_altitude_cm,
    output logic               o_divisor_zero,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);

    // configuration
    logic [47:0] r_temp_coeffs;
    logic [63:0] r_press_a;
    logic [63:0] r_press_b;
    logic [15:0] r_p9;
    logic [16:0] r_sea;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_coeffs <= '0;
            r_press_a     <= '0;
            r_press_b     <= '0;
            r_p9          <= '0;
            r_sea         <= bsc_pkg::DEFAULT_SEA_PA;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bsc_pkg::CFG_TEMP_COEFFS: r_temp_coeffs <= i_cfg_data[47:0];
                bsc_pkg::CFG_PRESS_A:     r_press_a     <= i_cfg_data;
                bsc_pkg::CFG_PRESS_B:     r_press_b     <= i_cfg_data;
                bsc_pkg::CFG_PRESS_NINE:  r_p9          <= i_cfg_data[15:0];
                bsc_pkg::CFG_SEA_LEVEL:   r_sea         <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    logic [15:0]        w_t1;
    logic signed [15:0] w_t2, w_t3;
    logic [15:0]        w_p1;
    logic signed [15:0] w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;
    logic [16:0]        w_p0;
    logic [24:0]        w_p0q;

    assign w_t1  = r_temp_coeffs[15:0];
    assign w_t2  = $signed(r_temp_coeffs[31:16]);
    assign w_t3  = $signed(r_temp_coeffs[47:32]);
    assign w_p1  = r_press_a[15:0];
    assign w_p2  = $signed(r_press_a[31:16]);
    assign w_p3  = $signed(r_press_a[47:32]);
    assign w_p4  = $signed(r_press_a[63:48]);
    assign w_p5  = $signed(r_press_b[15:0]);
    assign w_p6  = $signed(r_press_b[31:16]);
    assign w_p7  = $signed(r_press_b[47:32]);
    assign w_p8  = $signed(r_press_b[63:48]);
    assign w_p9  = $signed(r_p9);
    assign w_p0  = (r_sea == 17'd0) ? bsc_pkg::DEFAULT_SEA_PA : r_sea;
    assign w_p0q = {w_p0, 8'd0};

    // flow control
    logic w_adv;
    logic r_ov;
    assign w_adv   = !r_ov || i_ready;
    assign o_ready = w_adv;

    logic [12:1] r_va;
    logic [9:1]  r_vb;
    logic        w_d1_v, w_d2_v;

    // temperature and pressure front stages
    logic signed [17:0] r1_da;
    logic signed [16:0] r1_db;
    logic signed [33:0] r2_pa, r2_dd;
    logic signed [22:0] r3_va;
    logic signed [37:0] r3_vbp;
    logic signed [25:0] r4_tf;
    logic [23:0]        r5_temp;
    logic signed [26:0] r5_x1;
    logic [52:0]        r6_sq;
    logic signed [42:0] r6_m5, r6_m2;
    logic signed [48:0] r7_a6l, r7_a3l;
    logic signed [37:0] r7_a6h, r7_a3h;
    logic signed [42:0] r7_m5, r7_m2;
    logic [63:0]        r8_a6, r8_a3;
    logic signed [42:0] r8_m5, r8_m2;
    logic [63:0]        r9_x2, r9_x1b;
    logic [63:0]        r10_s, r10_n0;
    logic [47:0]        r11_pl;
    logic [31:0]        r11_ph;
    logic [43:0]        r11_nl;
    logic [31:0]        r11_nh;
    logic [63:0]        r12_prod, r12_num;
    logic [19:0]        r_adc_p [1:9];
    logic [23:0]        r_temp [6:12];

    logic signed [28:0] w_t5;
    logic signed [53:0] w_sq;
    logic [63:0]        w_a3s;
    logic [20:0]        w_pinv;
    logic [47:0]        w_ph, w_nh;

    assign w_t5   = $signed({{3{r4_tf[25]}}, r4_tf}) * $signed(29'sd5) + $signed(29'sd128);
    assign w_sq   = r5_x1 * r5_x1;
    assign w_a3s  = {{8{r8_a3[63]}}, r8_a3[63:8]};
    assign w_pinv = bsc_pkg::RAW_FULL_SCALE - {1'b0, r_adc_p[9]};
    assign w_ph   = r10_s[63:32] * w_p1;
    assign w_nh   = r10_n0[63:32] * bsc_pkg::PRESS_SCALE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= '0;
        end else if (w_adv) begin
            r_va <= {r_va[11:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_da      <= $signed({1'b0, i_raw_temp[19:3]}) - $signed({1'b0, w_t1, 1'b0});
            r1_db      <= $signed({1'b0, i_raw_temp[19:4]}) - $signed({1'b0, w_t1});
            r_adc_p[1] <= i_raw_press;

            r2_pa <= r1_da * w_t2;
            r2_dd <= r1_db * r1_db;

            r3_va  <= r2_pa[33:11];
            r3_vbp <= $signed({1'b0, r2_dd[32:12]}) * w_t3;

            r4_tf <= $signed({{3{r3_va[22]}}, r3_va})
                   + $signed({{2{r3_vbp[37]}}, r3_vbp[37:14]});

            r5_temp <= {{3{w_t5[28]}}, w_t5[28:8]};
            r5_x1   <= $signed({r4_tf[25], r4_tf}) - $signed(bsc_pkg::T_FINE_OFFSET);

            r6_sq  <= w_sq[52:0];
            r6_m5  <= r5_x1 * w_p5;
            r6_m2  <= r5_x1 * w_p2;

            r7_a6l <= $signed({1'b0, r6_sq[31:0]}) * w_p6;
            r7_a6h <= $signed({1'b0, r6_sq[52:32]}) * w_p6;
            r7_a3l <= $signed({1'b0, r6_sq[31:0]}) * w_p3;
            r7_a3h <= $signed({1'b0, r6_sq[52:32]}) * w_p3;
            r7_m5  <= r6_m5;
            r7_m2  <= r6_m2;

            r8_a6 <= {{15{r7_a6l[48]}}, r7_a6l} + {r7_a6h[31:0], 32'd0};
            r8_a3 <= {{15{r7_a3l[48]}}, r7_a3l} + {r7_a3h[31:0], 32'd0};
            r8_m5 <= r7_m5;
            r8_m2 <= r7_m2;

            r9_x2  <= r8_a6 + {{4{r8_m5[42]}}, r8_m5, 17'd0}
                    + {{13{w_p4[15]}}, w_p4, 35'd0};
            r9_x1b <= w_a3s + {{9{r8_m2[42]}}, r8_m2, 12'd0};

            r10_s  <= r9_x1b + bsc_pkg::X1_OFFSET;
            r10_n0 <= {12'd0, w_pinv, 31'd0} - r9_x2;

            r11_pl <= r10_s[31:0] * w_p1;
            r11_ph <= w_ph[31:0];
            r11_nl <= r10_n0[31:0] * bsc_pkg::PRESS_SCALE;
            r11_nh <= w_nh[31:0];

            r12_prod <= {r11_ph, 32'd0} + {16'd0, r11_pl};
            r12_num  <= {r11_nh, 32'd0} + {20'd0, r11_nl};

            r_temp[6] <= r5_temp;
            for (int k = 2; k <= 9; k++) begin
                r_adc_p[k] <= r_adc_p[k-1];
            end
            for (int k = 7; k <= 12; k++) begin
                r_temp[k] <= r_temp[k-1];
            end
        end
    end

    // pressure quotient
    bsc_pkg::t_tag w_tag1_in, w_tag1_out;
    logic [63:0]   w_q1;

    assign w_tag1_in.temp = r_temp[12];
    assign w_tag1_in.q8   = 32'd0;
    assign w_tag1_in.dz   = (r12_prod[63:33] == 31'd0);

    bsc_div u_div_press (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_va[12]),
        .i_num   (r12_num),
        .i_den   ({{2{r12_prod[63]}}, r12_prod[63:33]}),
        .i_tag   (w_tag1_in),
        .o_valid (w_d1_v),
        .o_quot  (w_q1),
        .o_tag   (w_tag1_out)
    );

    // pressure back stages and altitude numerator
    logic [63:0]        rd1_ll, rd1_p;
    logic [31:0]        rd1_lh, rd1_y2h;
    logic signed [48:0] rd1_y2l;
    logic [63:0]        rd2_sqp, rd2_y2p, rd2_p;
    logic signed [48:0] rd3_y1l;
    logic [31:0]        rd3_y1h;
    logic [63:0]        rd3_y2, rd3_p;
    logic [63:0]        rd4_y1p, rd4_y2, rd4_p;
    logic [63:0]        rd5_s;
    logic [63:0]        rd6_pf;
    logic [31:0]        rd7_q8;
    logic signed [33:0] rd8_diff;
    logic signed [54:0] rd9_num;
    logic [31:0]        rd_q8 [8:9];
    bsc_pkg::t_tag      rd_tag [1:9];

    logic [63:0]        w_ps, w_ll, w_lh, w_y2s, w_y1s, w_pfs;
    logic signed [48:0] w_y2l, w_y1l;
    logic signed [47:0] w_y2h, w_y1h;

    assign w_ps  = $signed(w_q1) >>> 13;
    assign w_ll  = w_ps[31:0] * w_ps[31:0];
    assign w_lh  = w_ps[31:0] * w_ps[63:32];
    assign w_y2l = $signed({1'b0, w_q1[31:0]}) * w_p8;
    assign w_y2h = $signed(w_q1[63:32]) * w_p8;
    assign w_y2s = $signed(rd2_y2p) >>> 19;
    assign w_y1l = $signed({1'b0, rd2_sqp[31:0]}) * w_p9;
    assign w_y1h = $signed(rd2_sqp[63:32]) * w_p9;
    assign w_y1s = $signed(rd4_y1p) >>> 25;
    assign w_pfs = $signed(rd5_s) >>> 8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= '0;
        end else if (w_adv) begin
            r_vb <= {r_vb[8:1], w_d1_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            rd1_ll    <= w_ll;
            rd1_lh    <= w_lh[31:0];
            rd1_y2l   <= w_y2l;
            rd1_y2h   <= w_y2h[31:0];
            rd1_p     <= w_q1;
            rd_tag[1] <= w_tag1_out;

            rd2_sqp <= rd1_ll + {rd1_lh[30:0], 33'd0};
            rd2_y2p <= {{15{rd1_y2l[48]}}, rd1_y2l} + {rd1_y2h, 32'd0};
            rd2_p   <= rd1_p;

            rd3_y1l <= w_y1l;
            rd3_y1h <= w_y1h[31:0];
            rd3_y2  <= w_y2s;
            rd3_p   <= rd2_p;

            rd4_y1p <= {{15{rd3_y1l[48]}}, rd3_y1l} + {rd3_y1h, 32'd0};
            rd4_y2  <= rd3_y2;
            rd4_p   <= rd3_p;

            rd5_s <= rd4_p + w_y1s + rd4_y2;

            rd6_pf <= w_pfs + {{44{w_p7[15]}}, w_p7, 4'd0};

            if (rd_tag[6].dz || rd6_pf[63]) begin
                rd7_q8 <= 32'd0;
            end else if (|rd6_pf[62:32]) begin
                rd7_q8 <= 32'hFFFF_FFFF;
            end else begin
                rd7_q8 <= rd6_pf[31:0];
            end

            rd8_diff <= $signed({9'd0, w_p0q}) - $signed({2'd0, rd7_q8});
            rd_q8[8] <= rd7_q8;

            rd9_num  <= rd8_diff * $signed({1'b0, bsc_pkg::ALT_SCALE_CM});
            rd_q8[9] <= rd_q8[8];

            for (int k = 2; k <= 9; k++) begin
                rd_tag[k] <= rd_tag[k-1];
            end
        end
    end

    // altitude quotient
    bsc_pkg::t_tag w_tag2_in, w_tag2_out;
    logic [63:0]   w_q2;

    assign w_tag2_in.temp = rd_tag[9].temp;
    assign w_tag2_in.q8   = rd_q8[9];
    assign w_tag2_in.dz   = rd_tag[9].dz;

    bsc_div u_div_alt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_vb[9]),
        .i_num   ({{9{rd9_num[54]}}, rd9_num}),
        .i_den   ({8'd0, w_p0q}),
        .i_tag   (w_tag2_in),
        .o_valid (w_d2_v),
        .o_quot  (w_q2),
        .o_tag   (w_tag2_out)
    );

    // output register
    logic [23:0] r_otemp, r_oalt;
    logic [31:0] r_oq8;
    logic        r_odz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_ov <= w_d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_otemp <= w_tag2_out.temp;
            r_oq8   <= w_tag2_out.q8;
            r_odz   <= w_tag2_out.dz;
            if (w_q2[63] && !(&w_q2[62:23])) begin
                r_oalt <= 24'h80_0000;
            end else if (!w_q2[63] && (|w_q2[62:23])) begin
                r_oalt <= 24'h7F_FFFF;
            end else begin
                r_oalt <= w_q2[23:0];
            end
        end
    end

    assign o_valid        = r_ov;
    assign o_temp_centi   = $signed(r_otemp);
    assign o_press_q8     = r_oq8;
    assign o_altitude_cm  = $signed(r_oalt);
    assign o_divisor_zero = r_odz;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divisor_zero |-> o_press_q8 == 32'd0)
        else $error("pressure not forced to zero on zero divisor");

    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled without a blocked result");

endmodule

// ----- design/bsc_div.sv -----
module bsc_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [63:0]      i_num,
    input  logic [32:0]      i_den,
    input  bsc_pkg::t_tag    i_tag,
    output logic             o_valid,
    output logic [63:0]      o_quot,
    output bsc_pkg::t_tag    o_tag
);

    logic [bsc_pkg::DIV_STEPS:0] r_v;
    logic [95:0]                 r_acc [0:bsc_pkg::DIV_STEPS];
    logic [31:0]                 r_d   [0:bsc_pkg::DIV_STEPS];
    logic                        r_neg [0:bsc_pkg::DIV_STEPS];
    bsc_pkg::t_tag               r_tag [0:bsc_pkg::DIV_STEPS];
    logic                        r_ov;
    logic [63:0]                 r_quot;
    bsc_pkg::t_tag               r_otag;

    logic [63:0] w_num_mag;
    logic [32:0] w_den_mag;
    logic [63:0] w_q;

    assign w_num_mag = i_num[63] ? (64'd0 - i_num) : i_num;
    assign w_den_mag = i_den[32] ? (33'd0 - i_den) : i_den;
    assign w_q       = r_acc[bsc_pkg::DIV_STEPS][63:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v  <= {r_v[bsc_pkg::DIV_STEPS-1:0], i_valid};
            r_ov <= r_v[bsc_pkg::DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc[0] <= {32'd0, w_num_mag};
            r_d[0]   <= w_den_mag[31:0];
            r_neg[0] <= i_num[63] ^ i_den[32];
            r_tag[0] <= i_tag;
            r_quot   <= r_neg[bsc_pkg::DIV_STEPS] ? (64'd0 - w_q) : w_q;
            r_otag   <= r_tag[bsc_pkg::DIV_STEPS];
        end
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= bsc_pkg::DIV_STEPS; k++) begin : g_step
        logic [32:0] w_t;
        logic [32:0] w_r;
        logic        w_ge;

        assign w_t  = r_acc[k-1][95:63];
        assign w_ge = (w_t >= {1'b0, r_d[k-1]});
        assign w_r  = w_ge ? (w_t - {1'b0, r_d[k-1]}) : w_t;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[k] <= {w_r[31:0], r_acc[k-1][62:0], w_ge};
                r_d[k]   <= r_d[k-1];
                r_neg[k] <= r_neg[k-1];
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    assign o_valid = r_ov;
    assign o_quot  = r_quot;
    assign o_tag   = r_otag;

endmodule
